FILE: rtl/dov6_pkg.sv
// Shared types, codes and constants for the DHCPv6 option extractor.
package dov6_pkg;

  localparam int OFF_W = 16;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  // Record kinds
  localparam logic [4:0] KIND_HEADER       = 5'd0;
  localparam logic [4:0] KIND_CLIENT_TYPE  = 5'd1;
  localparam logic [4:0] KIND_CLIENT_BYTE  = 5'd2;
  localparam logic [4:0] KIND_SERVER_TYPE  = 5'd3;
  localparam logic [4:0] KIND_SERVER_BYTE  = 5'd4;
  localparam logic [4:0] KIND_IA_NA        = 5'd5;
  localparam logic [4:0] KIND_IA_TA        = 5'd6;
  localparam logic [4:0] KIND_IAADDR       = 5'd7;
  localparam logic [4:0] KIND_DNS          = 5'd8;
  localparam logic [4:0] KIND_SIP          = 5'd9;
  localparam logic [4:0] KIND_NTP          = 5'd10;
  localparam logic [4:0] KIND_DOMAIN_BYTE  = 5'd11;
  localparam logic [4:0] KIND_RAPID        = 5'd12;
  localparam logic [4:0] KIND_USER_CLASS   = 5'd13;
  localparam logic [4:0] KIND_VENDOR_CLASS = 5'd14;
  localparam logic [4:0] KIND_VENDOR_OPTS  = 5'd15;
  localparam logic [4:0] KIND_IFACE_ID     = 5'd16;
  localparam logic [4:0] KIND_RECONF_MSG   = 5'd17;
  localparam logic [4:0] KIND_RECONF_ACC   = 5'd18;
  localparam logic [4:0] KIND_END          = 5'd19;

  // Option codes
  localparam logic [15:0] OPT_CLIENTID     = 16'd1;
  localparam logic [15:0] OPT_SERVERID     = 16'd2;
  localparam logic [15:0] OPT_IA_NA        = 16'd3;
  localparam logic [15:0] OPT_IA_TA        = 16'd4;
  localparam logic [15:0] OPT_IAADDR       = 16'd5;
  localparam logic [15:0] OPT_RAPID        = 16'd14;
  localparam logic [15:0] OPT_USER_CLASS   = 16'd15;
  localparam logic [15:0] OPT_VENDOR_CLASS = 16'd16;
  localparam logic [15:0] OPT_VENDOR_OPTS  = 16'd17;
  localparam logic [15:0] OPT_IFACE_ID     = 16'd18;
  localparam logic [15:0] OPT_RECONF_MSG   = 16'd19;
  localparam logic [15:0] OPT_RECONF_ACC   = 16'd20;
  localparam logic [15:0] OPT_SIP          = 16'd21;
  localparam logic [15:0] OPT_DNS          = 16'd23;
  localparam logic [15:0] OPT_DOMAIN       = 16'd24;
  localparam logic [15:0] OPT_NTP          = 16'd56;
  localparam logic [15:0] OPT_END          = 16'd255;

  // Packet status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PORTS    = 3'd1;
  localparam logic [2:0] ST_NOT_V6   = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_CLIENT_PORT = 2'd0;
  localparam logic [1:0] REG_SERVER_PORT = 2'd1;
  localparam logic [1:0] REG_DUID_LIMIT  = 2'd2;

  localparam logic [7:0] MSG_TYPE_MIN = 8'd1;
  localparam logic [7:0] MSG_TYPE_MAX = 8'd13;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] third;
    logic [31:0] fourth;
    logic [15:0] idx;
    logic [2:0]  status;
    logic        trunc;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [15:0] client_port;
    logic [15:0] server_port;
    logic [15:0] duid_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

endpackage

FILE: rtl/dov6_if.sv
// Request channel interfaces for payload bytes and result records.
interface dov6_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        first_byte;
  logic        final_byte;
  logic [15:0] payload_length;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic        is_ipv6;

  modport source (output valid, payload_byte, first_byte, final_byte, payload_length,
                  source_port, dest_port, is_ipv6, input ready);
  modport sink (input valid, payload_byte, first_byte, final_byte, payload_length,
                source_port, dest_port, is_ipv6, output ready);
endinterface

interface dov6_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  record_kind;
  logic [63:0] value_high;
  logic [63:0] value_low;
  logic [31:0] value_third;
  logic [31:0] value_fourth;
  logic [15:0] item_index;
  logic [2:0]  packet_status;
  logic        options_truncated;
  logic        last_of_run;

  modport source (output valid, record_kind, value_high, value_low, value_third,
                  value_fourth, item_index, packet_status, options_truncated,
                  last_of_run, input ready);
  modport sink (input valid, record_kind, value_high, value_low, value_third,
                value_fourth, item_index, packet_status, options_truncated,
                last_of_run, output ready);
endinterface

FILE: rtl/dhcpv6_option_extractor.sv
// Top level of the DHCPv6 option extractor.
// Records: a record is written into the result queue as the byte that causes it is accepted.
// Throughput: one byte per cycle while the four-entry result queue has room for two
// records; the queue emits its records one at a time.
// Reset: synchronous active-low rst_n clears parser state and the queue and
// restores the port and DUID limit registers to their defaults.
module dhcpv6_option_extractor import dov6_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dov6_in_if.sink     in_chan,
  dov6_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  logic  space_ok, push_en;
  push_t push;

  dov6_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  dov6_parse u_parse (
    .clk, .rst_n, .cfg, .space_ok, .in_chan, .push_en, .push
  );

  dov6_outq u_outq (
    .clk, .rst_n, .push_en, .push, .space_ok, .out_chan
  );

endmodule

FILE: rtl/dov6_cfg.sv
// APB configuration registers: client port, server port, DUID byte limit.
module dov6_cfg import dov6_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.client_port <= 16'd546;
      cfg_r.server_port <= 16'd547;
      cfg_r.duid_limit  <= 16'd128;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CLIENT_PORT: cfg_r.client_port <= pwdata[15:0];
        REG_SERVER_PORT: cfg_r.server_port <= pwdata[15:0];
        REG_DUID_LIMIT:  cfg_r.duid_limit  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_CLIENT_PORT: prdata = {16'd0, cfg_r.client_port};
      REG_SERVER_PORT: prdata = {16'd0, cfg_r.server_port};
      REG_DUID_LIMIT:  prdata = {16'd0, cfg_r.duid_limit};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/dov6_parse.sv
// Per-byte DHCPv6 header and option parser producing up to two records.
module dov6_parse import dov6_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   space_ok,
  dov6_in_if.sink in_chan,
  output logic   push_en,
  output push_t  push
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_OPTHDR, PH_OPTDATA, PH_DONE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [OFF_W-1:0] off_r, off_nxt, plen_r, plen_nxt;
  logic [2:0]      rej_r, rej_nxt;
  logic [15:0]     ocode_r, ocode_nxt, olen_r, olen_nxt, opos_r, opos_nxt;
  logic [31:0]     hs_r, hs_nxt;
  logic [31:0]     acc_r [6];
  logic [31:0]     acc_nxt [6];
  logic [7:0]      dll_r, dll_nxt;
  logic            stop_r, stop_nxt, trunc_r, trunc_nxt;

  logic            accept, ports_ok, srv_list, proc_v;
  logic [7:0]      b;
  logic [15:0]     pos;
  logic [13:0]     w;
  logic [OFF_W+16:0] opt_end;
  logic [2:0]      status;
  rec_t            proc_rec, end_rec;
  logic            end_v;

  assign accept        = in_chan.valid & space_ok;
  assign in_chan.ready = space_ok;
  assign b             = in_chan.payload_byte;
  assign ports_ok = (in_chan.source_port == cfg.client_port &&
                     in_chan.dest_port == cfg.server_port) ||
                    (in_chan.source_port == cfg.server_port &&
                     in_chan.dest_port == cfg.client_port);

  // Next state and records for the byte on the input
  always_comb begin
    phase_nxt = phase_r;  off_nxt = off_r;    plen_nxt = plen_r;
    rej_nxt = rej_r;      ocode_nxt = ocode_r; olen_nxt = olen_r;
    opos_nxt = opos_r;    hs_nxt = hs_r;      dll_nxt = dll_r;
    stop_nxt = stop_r;    trunc_nxt = trunc_r;
    for (int i = 0; i < 6; i++) acc_nxt[i] = acc_r[i];
    proc_v = 1'b0; proc_rec = '0; end_v = 1'b0; end_rec = '0;
    pos = 16'd0; w = 14'd0; srv_list = 1'b0; opt_end = '0; status = ST_OK;

    // Open a new packet
    if (in_chan.first_byte) begin
      off_nxt = '0;
      if (in_chan.payload_length > 16'(OFF_MAX))
        plen_nxt = OFF_MAX;
      else
        plen_nxt = in_chan.payload_length[OFF_W-1:0];
      rej_nxt = !ports_ok ? ST_PORTS : !in_chan.is_ipv6 ? ST_NOT_V6 :
                (plen_nxt < OFF_W'(4)) ? ST_SHORT : ST_OK;
      stop_nxt  = rej_nxt != ST_OK;
      trunc_nxt = 1'b0;
      phase_nxt = stop_nxt ? PH_DONE : PH_HEADER;
      ocode_nxt = '0; olen_nxt = '0; opos_nxt = '0; hs_nxt = '0; dll_nxt = '0;
      for (int i = 0; i < 6; i++) acc_nxt[i] = '0;
    end

    if (phase_nxt != PH_IDLE && off_nxt < plen_nxt) begin
      case (phase_nxt)
        PH_HEADER: begin
          hs_nxt = {hs_nxt[23:0], b};
          if (off_nxt == '0 && (b < MSG_TYPE_MIN || b > MSG_TYPE_MAX)) begin
            rej_nxt = ST_BAD_TYPE; stop_nxt = 1'b1; phase_nxt = PH_DONE;
          end else if (off_nxt == OFF_W'(3)) begin
            proc_v = 1'b1;
            proc_rec.kind = KIND_HEADER;
            proc_rec.hi   = {56'd0, hs_nxt[31:24]};
            proc_rec.lo   = {40'd0, hs_nxt[23:0]};
            hs_nxt = '0; opos_nxt = '0; phase_nxt = PH_OPTHDR;
          end
        end
        PH_OPTHDR: begin
          hs_nxt   = {hs_nxt[23:0], b};
          opos_nxt = opos_nxt + 16'd1;
          if (opos_nxt >= 16'd4) begin
            ocode_nxt = hs_nxt[31:16];
            olen_nxt  = hs_nxt[15:0];
            opt_end = (OFF_W+17)'(off_nxt) + (OFF_W+17)'(1) + (OFF_W+17)'(olen_nxt);
            for (int i = 0; i < 6; i++) acc_nxt[i] = '0;
            dll_nxt = '0; opos_nxt = '0;
            if (opt_end > (OFF_W+17)'(plen_nxt)) begin
              trunc_nxt = 1'b1; stop_nxt = 1'b1; phase_nxt = PH_DONE;
            end else if (ocode_nxt == OPT_END) begin
              stop_nxt = 1'b1; phase_nxt = PH_DONE;
            end else begin
              if (ocode_nxt == OPT_RAPID) begin
                proc_v = 1'b1; proc_rec.kind = KIND_RAPID;
              end else if (ocode_nxt == OPT_RECONF_ACC) begin
                proc_v = 1'b1; proc_rec.kind = KIND_RECONF_ACC;
              end else if (ocode_nxt == OPT_USER_CLASS && olen_nxt != '0) begin
                proc_v = 1'b1; proc_rec.kind = KIND_USER_CLASS;
                proc_rec.hi = {48'd0, olen_nxt};
              end else if (ocode_nxt == OPT_IFACE_ID && olen_nxt != '0) begin
                proc_v = 1'b1; proc_rec.kind = KIND_IFACE_ID;
                proc_rec.hi = {48'd0, olen_nxt};
              end
              phase_nxt = (olen_nxt != '0) ? PH_OPTDATA : PH_OPTHDR;
            end
          end
        end
        PH_OPTDATA: begin
          pos      = opos_nxt;
          srv_list = ocode_nxt == OPT_DNS || ocode_nxt == OPT_SIP || ocode_nxt == OPT_NTP;
          w        = srv_list ? {12'd0, pos[3:2]} : pos[15:2];
          // Shift the byte into its accumulator word
          if (w < 14'd6) acc_nxt[w[2:0]] = {acc_nxt[w[2:0]][23:0], b};

          if (ocode_nxt == OPT_CLIENTID || ocode_nxt == OPT_SERVERID) begin
            if (pos == 16'd1) begin
              proc_v = 1'b1;
              proc_rec.kind = (ocode_nxt == OPT_CLIENTID) ? KIND_CLIENT_TYPE
                                                          : KIND_SERVER_TYPE;
              proc_rec.hi = {48'd0, acc_nxt[0][15:0]};
            end else if (pos >= 16'd2 && (pos - 16'd2) < cfg.duid_limit) begin
              proc_v = 1'b1;
              proc_rec.kind = (ocode_nxt == OPT_CLIENTID) ? KIND_CLIENT_BYTE
                                                          : KIND_SERVER_BYTE;
              proc_rec.hi  = {56'd0, b};
              proc_rec.idx = pos - 16'd2;
            end
          end else if (ocode_nxt == OPT_IA_NA) begin
            if (pos == 16'd11) begin
              proc_v = 1'b1; proc_rec.kind = KIND_IA_NA;
              proc_rec.hi = {32'd0, acc_nxt[0]};
              proc_rec.lo = {32'd0, acc_nxt[1]};
              proc_rec.third = acc_nxt[2];
            end
          end else if (ocode_nxt == OPT_IA_TA || ocode_nxt == OPT_VENDOR_CLASS ||
                       ocode_nxt == OPT_VENDOR_OPTS) begin
            if (pos == 16'd3) begin
              proc_v = 1'b1;
              proc_rec.kind = (ocode_nxt == OPT_IA_TA) ? KIND_IA_TA :
                              (ocode_nxt == OPT_VENDOR_CLASS) ? KIND_VENDOR_CLASS
                                                              : KIND_VENDOR_OPTS;
              proc_rec.hi = {32'd0, acc_nxt[0]};
            end
          end else if (ocode_nxt == OPT_IAADDR) begin
            if (pos == 16'd23) begin
              proc_v = 1'b1; proc_rec.kind = KIND_IAADDR;
              proc_rec.hi = {acc_nxt[0], acc_nxt[1]};
              proc_rec.lo = {acc_nxt[2], acc_nxt[3]};
              proc_rec.third  = acc_nxt[4];
              proc_rec.fourth = acc_nxt[5];
            end
          end else if (srv_list) begin
            if (pos[3:0] == 4'hf && olen_nxt[3:0] == 4'h0) begin
              proc_v = 1'b1;
              proc_rec.kind = (ocode_nxt == OPT_DNS) ? KIND_DNS :
                              (ocode_nxt == OPT_SIP) ? KIND_SIP : KIND_NTP;
              proc_rec.hi  = {acc_nxt[0], acc_nxt[1]};
              proc_rec.lo  = {acc_nxt[2], acc_nxt[3]};
              proc_rec.idx = {4'd0, pos[15:4]};
            end
          end else if (ocode_nxt == OPT_DOMAIN) begin
            if (pos == 16'd0) begin
              dll_nxt = (b != 8'd0 && {8'd0, b} < olen_nxt) ? b : 8'd0;
            end else if (pos <= {8'd0, dll_nxt}) begin
              proc_v = 1'b1; proc_rec.kind = KIND_DOMAIN_BYTE;
              proc_rec.hi  = {56'd0, b};
              proc_rec.idx = pos - 16'd1;
            end
          end else if (ocode_nxt == OPT_RECONF_MSG) begin
            if (pos == 16'd0) begin
              proc_v = 1'b1; proc_rec.kind = KIND_RECONF_MSG;
              proc_rec.hi = {56'd0, b};
            end
          end

          // Advance within the option
          opos_nxt = pos + 16'd1;
          if (opos_nxt >= olen_nxt) begin
            opos_nxt = '0; hs_nxt = '0; phase_nxt = PH_OPTHDR;
          end
        end
        default: ;
      endcase
      if (off_nxt < OFF_MAX) off_nxt = off_nxt + OFF_W'(1);
    end

    // Close the packet with a status record
    if (in_chan.final_byte && phase_nxt != PH_IDLE) begin
      status = rej_nxt;
      if (status == ST_OK && phase_nxt == PH_HEADER) status = ST_SHORT;
      if (phase_nxt == PH_OPTDATA) trunc_nxt = 1'b1;
      end_v = 1'b1;
      end_rec.kind   = KIND_END;
      end_rec.status = status;
      end_rec.trunc  = trunc_nxt;
      end_rec.last   = 1'b1;
      phase_nxt = PH_IDLE;
    end
    if (!end_v) proc_rec.last = 1'b1;
  end

  // Pack the records in order
  always_comb begin
    push_en = accept;
    push.count = {1'b0, proc_v} + {1'b0, end_v};
    push.rec0  = proc_v ? proc_rec : end_rec;
    push.rec1  = end_rec;
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; off_r <= '0; plen_r <= '0; rej_r <= ST_OK;
      ocode_r <= '0; olen_r <= '0; opos_r <= '0; hs_r <= '0; dll_r <= '0;
      stop_r <= 1'b0; trunc_r <= 1'b0;
      for (int i = 0; i < 6; i++) acc_r[i] <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt; off_r <= off_nxt; plen_r <= plen_nxt; rej_r <= rej_nxt;
      ocode_r <= ocode_nxt; olen_r <= olen_nxt; opos_r <= opos_nxt; hs_r <= hs_nxt;
      dll_r <= dll_nxt; stop_r <= stop_nxt; trunc_r <= trunc_nxt;
      for (int i = 0; i < 6; i++) acc_r[i] <= acc_nxt[i];
    end
  end

endmodule

FILE: rtl/dov6_outq.sv
// Four-entry result queue taking up to two records a cycle, emitting one.
module dov6_outq import dov6_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_en,
  input  push_t  push,
  output logic   space_ok,
  dov6_out_if.source out_chan
);

  rec_t       mem_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_in;
  logic       pop;
  rec_t       head;

  assign n_in     = push_en ? push.count : 2'd0;
  assign pop      = out_chan.valid & out_chan.ready;
  assign space_ok = cnt_r <= 3'd2;
  assign cnt_nxt  = cnt_r + {1'b0, n_in} - {2'd0, pop};
  assign head     = mem_r[rd_r];

  // Store incoming records
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) mem_r[wr_r] <= push.rec0;
    if (n_in == 2'd2) mem_r[wr_r + 2'd1] <= push.rec1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + n_in;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

  assign out_chan.valid             = cnt_r != 3'd0;
  assign out_chan.record_kind       = head.kind;
  assign out_chan.value_high        = head.hi;
  assign out_chan.value_low         = head.lo;
  assign out_chan.value_third       = head.third;
  assign out_chan.value_fourth      = head.fourth;
  assign out_chan.item_index        = head.idx;
  assign out_chan.packet_status     = head.status;
  assign out_chan.options_truncated = head.trunc;
  assign out_chan.last_of_run       = head.last;

endmodule

FILE: tb/sv/tb_dhcpv6_option_extractor.sv
// Testbench for the DHCPv6 option extractor: directed and random packets checked against a local predictor.
`timescale 1ns / 1ps
module tb_dhcpv6_option_extractor;
  import dov6_pkg::*;

  typedef struct {
    logic [7:0]  b;
    logic        first;
    logic        fin;
    logic [15:0] len;
    logic [15:0] sp;
    logic [15:0] dp;
    logic        v6;
  } byte_req_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dov6_in_if  in_chan ();
  dov6_out_if out_chan ();

  dhcpv6_option_extractor u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  byte_req_t pending_bytes[$];
  rec_t      expected_recs[$];
  int        errors = 0;
  bit        stim_done = 0;
  bit        send_hold = 0;
  int        hold_rx = 0;

  // Predictor state
  logic [15:0] p_client, p_server, p_limit;
  logic [15:0] p_off, p_plen, p_ocode, p_olen, p_opos;
  logic [2:0]  p_phase, p_rej;
  logic [31:0] p_hshift;
  logic [31:0] p_acc[6];
  logic [7:0]  p_dlen;
  logic        p_trunc;
  rec_t        run_recs[$];

  localparam logic [2:0] PH_IDLE = 3'd0, PH_HEADER = 3'd1, PH_OPTHDR = 3'd2,
                         PH_OPTDATA = 3'd3, PH_DONE = 3'd4;

  function automatic rec_t mk(logic [4:0] k, logic [63:0] hi, logic [63:0] lo,
                              logic [31:0] t, logic [31:0] f, logic [15:0] ix);
    rec_t r;
    r = '0;
    r.kind = k; r.hi = hi; r.lo = lo; r.third = t; r.fourth = f; r.idx = ix;
    return r;
  endfunction

  function automatic bit is_srv(logic [15:0] c);
    return c == OPT_DNS || c == OPT_SIP || c == OPT_NTP;
  endfunction

  task automatic clear_opt();
    for (int i = 0; i < 6; i++) p_acc[i] = '0;
    p_dlen = '0;
    p_opos = '0;
  endtask

  task automatic opt_hdr_done();
    int fin_pos;
    fin_pos = int'(p_off) + 1 + int'(p_olen);
    clear_opt();
    if (fin_pos > int'(p_plen)) begin
      p_trunc = 1; p_phase = PH_DONE; return;
    end
    if (p_ocode == OPT_END) begin
      p_phase = PH_DONE; return;
    end
    if (p_ocode == OPT_RAPID) run_recs.push_back(mk(KIND_RAPID, 0, 0, 0, 0, 0));
    else if (p_ocode == OPT_RECONF_ACC) run_recs.push_back(mk(KIND_RECONF_ACC, 0, 0, 0, 0, 0));
    else if (p_ocode == OPT_USER_CLASS && p_olen > 0)
      run_recs.push_back(mk(KIND_USER_CLASS, 64'(p_olen), 0, 0, 0, 0));
    else if (p_ocode == OPT_IFACE_ID && p_olen > 0)
      run_recs.push_back(mk(KIND_IFACE_ID, 64'(p_olen), 0, 0, 0, 0));
    p_phase = (p_olen > 0) ? PH_OPTDATA : PH_OPTHDR;
  endtask

  task automatic opt_data(logic [7:0] b);
    logic [15:0] pos, c;
    int w;
    logic [4:0] k;
    pos = p_opos; c = p_ocode;
    w = is_srv(c) ? int'(pos[3:2]) : int'(pos >> 2);
    if (w < 6) p_acc[w] = {p_acc[w][23:0], b};
    if (c == OPT_CLIENTID || c == OPT_SERVERID) begin
      k = (c == OPT_CLIENTID) ? KIND_CLIENT_TYPE : KIND_SERVER_TYPE;
      if (pos == 1) run_recs.push_back(mk(k, 64'(p_acc[0][15:0]), 0, 0, 0, 0));
      else if (pos >= 2 && (pos - 16'd2) < p_limit)
        run_recs.push_back(mk(k + 5'd1, 64'(b), 0, 0, 0, pos - 16'd2));
    end else if (c == OPT_IA_NA) begin
      if (pos == 11) run_recs.push_back(mk(KIND_IA_NA, 64'(p_acc[0]), 64'(p_acc[1]),
                                           p_acc[2], 0, 0));
    end else if (c == OPT_IA_TA || c == OPT_VENDOR_CLASS || c == OPT_VENDOR_OPTS) begin
      k = (c == OPT_IA_TA) ? KIND_IA_TA : (c == OPT_VENDOR_CLASS) ? KIND_VENDOR_CLASS
                                                                  : KIND_VENDOR_OPTS;
      if (pos == 3) run_recs.push_back(mk(k, 64'(p_acc[0]), 0, 0, 0, 0));
    end else if (c == OPT_IAADDR) begin
      if (pos == 23) run_recs.push_back(mk(KIND_IAADDR, {p_acc[0], p_acc[1]},
                                           {p_acc[2], p_acc[3]}, p_acc[4], p_acc[5], 0));
    end else if (is_srv(c)) begin
      if (pos[3:0] == 4'hf && p_olen[3:0] == 4'h0) begin
        k = (c == OPT_DNS) ? KIND_DNS : (c == OPT_SIP) ? KIND_SIP : KIND_NTP;
        run_recs.push_back(mk(k, {p_acc[0], p_acc[1]}, {p_acc[2], p_acc[3]}, 0, 0, pos >> 4));
      end
    end else if (c == OPT_DOMAIN) begin
      if (pos == 0) p_dlen = (b > 0 && 16'(b) < p_olen) ? b : 8'd0;
      else if (pos <= 16'(p_dlen))
        run_recs.push_back(mk(KIND_DOMAIN_BYTE, 64'(b), 0, 0, 0, pos - 16'd1));
    end else if (c == OPT_RECONF_MSG) begin
      if (pos == 0) run_recs.push_back(mk(KIND_RECONF_MSG, 64'(b), 0, 0, 0, 0));
    end
    p_opos = pos + 16'd1;
    if (p_opos >= p_olen) begin
      p_opos = 0; p_hshift = 0; p_phase = PH_OPTHDR;
    end
  endtask

  // Work out the records that one accepted byte causes and queue them.
  task automatic predict_byte(byte_req_t t);
    rec_t e;
    logic ports;
    logic [2:0] st;
    run_recs.delete();
    if (t.first) begin
      ports = (t.sp == p_client && t.dp == p_server) || (t.sp == p_server && t.dp == p_client);
      p_off = 0;
      p_plen = (t.len > 16'(OFF_MAX)) ? 16'(OFF_MAX) : t.len;
      p_rej = !ports ? ST_PORTS : !t.v6 ? ST_NOT_V6 : (p_plen < 4) ? ST_SHORT : ST_OK;
      p_trunc = 0;
      p_phase = (p_rej != ST_OK) ? PH_DONE : PH_HEADER;
      p_ocode = 0; p_olen = 0; p_hshift = 0;
      clear_opt();
    end
    if (p_phase != PH_IDLE && p_off < p_plen) begin
      if (p_phase == PH_HEADER) begin
        p_hshift = {p_hshift[23:0], t.b};
        if (p_off == 0 && (t.b < MSG_TYPE_MIN || t.b > MSG_TYPE_MAX)) begin
          p_rej = ST_BAD_TYPE; p_phase = PH_DONE;
        end else if (p_off == 3) begin
          run_recs.push_back(mk(KIND_HEADER, 64'(p_hshift[31:24]), 64'(p_hshift[23:0]),
                                0, 0, 0));
          p_hshift = 0; p_opos = 0; p_phase = PH_OPTHDR;
        end
      end else if (p_phase == PH_OPTHDR) begin
        p_hshift = {p_hshift[23:0], t.b};
        p_opos++;
        if (p_opos >= 4) begin
          p_ocode = p_hshift[31:16]; p_olen = p_hshift[15:0];
          opt_hdr_done();
        end
      end else if (p_phase == PH_OPTDATA) begin
        opt_data(t.b);
      end
      if (p_off != 16'(OFF_MAX)) p_off++;
    end
    if (t.fin && p_phase != PH_IDLE) begin
      st = p_rej;
      if (st == ST_OK && p_phase == PH_HEADER) st = ST_SHORT;
      if (p_phase == PH_OPTDATA) p_trunc = 1;
      e = mk(KIND_END, 0, 0, 0, 0, 0);
      e.status = st; e.trunc = p_trunc;
      run_recs.push_back(e);
      p_phase = PH_IDLE;
    end
    if (run_recs.size() > 0) run_recs[run_recs.size()-1].last = 1;
    foreach (run_recs[i]) expected_recs.push_back(run_recs[i]);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: offer pending bytes with random gaps.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) predict_byte(pending_bytes.pop_front());
      if (in_chan.valid && !in_chan.ready) begin
        // hold the offered request
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_chan.valid <= 0;
      end else if (!send_hold && pending_bytes.size() > ((in_chan.valid && in_chan.ready) ? 0 : 0)
                   && pending_bytes.size() > 0) begin
        in_chan.valid <= 1;
        in_chan.payload_byte <= pending_bytes[0].b;
        in_chan.first_byte <= pending_bytes[0].first;
        in_chan.final_byte <= pending_bytes[0].fin;
        in_chan.payload_length <= pending_bytes[0].len;
        in_chan.source_port <= pending_bytes[0].sp;
        in_chan.dest_port <= pending_bytes[0].dp;
        in_chan.is_ipv6 <= pending_bytes[0].v6;
        send_gap <= gap_len();
      end else begin
        in_chan.valid <= 0;
      end
    end
  end

  // Monitor: stall at random and compare records with the oldest expectation.
  int recv_gap = 0;
  always @(posedge clk) begin
    rec_t e;
    if (!rst_n) begin
      out_chan.ready <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_recs.size() == 0) begin
          $display("%0t: unexpected record kind %0d", $time, out_chan.record_kind);
          errors++;
        end else begin
          e = expected_recs.pop_front();
          if (e.kind !== out_chan.record_kind || e.hi !== out_chan.value_high ||
              e.lo !== out_chan.value_low || e.third !== out_chan.value_third ||
              e.fourth !== out_chan.value_fourth || e.idx !== out_chan.item_index ||
              e.status !== out_chan.packet_status || e.trunc !== out_chan.options_truncated ||
              e.last !== out_chan.last_of_run) begin
            $display("%0t: mismatch expected k=%0d hi=%h lo=%h t=%h f=%h ix=%0d st=%0d tr=%b l=%b",
                     $time, e.kind, e.hi, e.lo, e.third, e.fourth, e.idx, e.status, e.trunc,
                     e.last);
            $display("%0t:          actual   k=%0d hi=%h lo=%h t=%h f=%h ix=%0d st=%0d tr=%b l=%b",
                     $time, out_chan.record_kind, out_chan.value_high, out_chan.value_low,
                     out_chan.value_third, out_chan.value_fourth, out_chan.item_index,
                     out_chan.packet_status, out_chan.options_truncated, out_chan.last_of_run);
            errors++;
          end
        end
      end
      if (hold_rx > 0) begin
        hold_rx <= hold_rx - 1;
        out_chan.ready <= 0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_chan.ready <= 0;
      end else begin
        out_chan.ready <= 1;
        recv_gap <= gap_len();
      end
    end
  end

  // Watchdog on cycles with no accepted byte or record.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || !rst_n)
      idle_cycles <= 0;
    else if (hold_rx == 0)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [15:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= {16'h0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_CLIENT_PORT) p_client = v;
    else if (idx == REG_SERVER_PORT) p_server = v;
    else p_limit = v;
  endtask

  task automatic push_byte(logic [7:0] b, bit first, bit fin, logic [15:0] len,
                           logic [15:0] sp, logic [15:0] dp, bit v6);
    byte_req_t t;
    t.b = b; t.first = first; t.fin = fin; t.len = len; t.sp = sp; t.dp = dp; t.v6 = v6;
    pending_bytes.push_back(t);
  endtask

  // Build a packet body from random options, mostly well-formed.
  task automatic push_packet(int status_sel, bit swap);
    logic [7:0] body[$];
    logic [15:0] codes[18];
    logic [15:0] c, l, len;
    logic [15:0] sp, dp;
    int nopt, r;
    bit v6;
    codes = '{OPT_CLIENTID, OPT_SERVERID, OPT_IA_NA, OPT_IA_TA, OPT_IAADDR, OPT_RAPID,
              OPT_USER_CLASS, OPT_VENDOR_CLASS, OPT_VENDOR_OPTS, OPT_IFACE_ID,
              OPT_RECONF_MSG, OPT_RECONF_ACC, OPT_SIP, OPT_DNS, OPT_DOMAIN, OPT_NTP,
              OPT_END, 16'd99};
    body.push_back($urandom_range(0, 19) == 0 ? 8'($urandom) : 8'($urandom_range(1, 13)));
    repeat (3) body.push_back(8'($urandom));
    nopt = $urandom_range(0, 4);
    repeat (nopt) begin
      c = codes[$urandom_range(0, 17)];
      if ($urandom_range(0, 30) == 0) c = 16'($urandom);
      case (c)
        OPT_IA_NA: l = 16'd12;
        OPT_IAADDR: l = 16'd24;
        OPT_IA_TA, OPT_VENDOR_CLASS, OPT_VENDOR_OPTS: l = 16'd4;
        OPT_SIP, OPT_DNS, OPT_NTP: l = 16'(16 * $urandom_range(1, 2));
        default: l = 16'($urandom_range(0, 12));
      endcase
      if ($urandom_range(0, 7) == 0) l = 16'($urandom_range(0, 30));
      body.push_back(c[15:8]); body.push_back(c[7:0]);
      body.push_back(l[15:8]); body.push_back(l[7:0]);
      for (int i = 0; i < l; i++)
        body.push_back((c == OPT_DOMAIN && i == 0) ? 8'($urandom_range(0, 12)) : 8'($urandom));
    end
    len = 16'(body.size());
    r = $urandom_range(0, 9);
    if (r == 0) len = len - 16'($urandom_range(0, 6));
    else if (r == 1) len = len + 16'($urandom_range(0, 6));
    else if (r == 2) len = 16'hffff;
    v6 = (status_sel != 2);
    sp = swap ? p_server : p_client;
    dp = swap ? p_client : p_server;
    if (status_sel == 1) sp = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      // drop bytes from the end to end the packet early
      r = $urandom_range(0, 8);
      while (r > 0 && body.size() > 1) begin void'(body.pop_back()); r--; end
    end
    foreach (body[i])
      push_byte(body[i], i == 0, i == body.size() - 1, len, sp, dp, v6);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() > 0 || in_chan.valid || expected_recs.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    in_chan.valid = 0; in_chan.payload_byte = 0; in_chan.first_byte = 0;
    in_chan.final_byte = 0; in_chan.payload_length = 0; in_chan.source_port = 0;
    in_chan.dest_port = 0; in_chan.is_ipv6 = 0; out_chan.ready = 0;
    p_client = 16'd546; p_server = 16'd547; p_limit = 16'd128;
    p_phase = PH_IDLE; p_off = 0; p_plen = 0; p_rej = 0; p_ocode = 0; p_olen = 0;
    p_hshift = 0; p_trunc = 0; clear_opt();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset ports, stray byte with no packet, reject paths, early end.
    push_byte(8'hff, 0, 1, 0, 0, 0, 0);
    push_byte(8'd1, 1, 1, 4, 16'd546, 16'd547, 0);
    push_byte(8'd1, 1, 1, 4, 16'd1, 16'd547, 1);
    push_byte(8'd1, 1, 0, 3, 16'd547, 16'd546, 1);
    push_byte(8'd0, 1, 1, 3, 16'd547, 16'd546, 1);
    push_byte(8'd14, 1, 0, 8, 16'd546, 16'd547, 1);
    push_byte(8'd13, 1, 0, 8, 16'd546, 16'd547, 1);
    push_byte(8'hab, 0, 1, 8, 0, 0, 0);
    push_byte(8'd1, 1, 0, 16'hffff, 16'd546, 16'd547, 1);
    push_byte(8'hff, 0, 0, 0, 0, 0, 0);
    push_byte(8'hff, 0, 0, 0, 0, 0, 0);
    push_byte(8'hff, 0, 0, 0, 0, 0, 0);
    push_byte(8'h00, 0, 0, 0, 0, 0, 0);
    push_byte(8'h0e, 0, 0, 0, 0, 0, 0);
    push_byte(8'h00, 0, 0, 0, 0, 0, 0);
    push_byte(8'h00, 0, 1, 0, 0, 0, 0);
    wait_drained();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin apb_write(REG_DUID_LIMIT, 16'd0); end
        1: begin apb_write(REG_CLIENT_PORT, 16'hffff); apb_write(REG_SERVER_PORT, 16'h0000);
                 apb_write(REG_DUID_LIMIT, 16'hffff); end
        2: begin apb_write(REG_CLIENT_PORT, 16'($urandom));
                 apb_write(REG_SERVER_PORT, 16'($urandom));
                 apb_write(REG_DUID_LIMIT, 16'($urandom_range(1, 6))); end
        3: begin apb_write(REG_CLIENT_PORT, 16'h5a5a); apb_write(REG_SERVER_PORT, 16'h5a5a); end
        4: begin apb_write(REG_CLIENT_PORT, 16'd546); apb_write(REG_SERVER_PORT, 16'd547);
                 apb_write(REG_DUID_LIMIT, 16'd128); end
        default: apb_write(REG_DUID_LIMIT, 16'd3);
      endcase
      while (pending_bytes.size() < 150) begin
        r_sel();
      end
      if (ph == 2) begin
        // Stall the receiver for a long stretch so the block backs up.
        hold_rx <= 300;
      end
      if (ph == 3) begin
        while (pending_bytes.size() > 80) @(posedge clk);
        send_hold <= 1;
        while (in_chan.valid || expected_recs.size() > 0) @(posedge clk);
        send_hold <= 0;
      end
      wait_drained();
    end
    stim_done = 1;
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_recs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic r_sel();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) push_packet(1, 1'($urandom_range(0, 1)));
    else if (r == 1) push_packet(2, 1'($urandom_range(0, 1)));
    else if (r == 2) push_byte(8'($urandom), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                               16'($urandom), 1'($urandom_range(0, 1)));
    else push_packet(0, 1'($urandom_range(0, 1)));
  endtask

endmodule
